FILE: design/tlc_pkg.sv
// Shared constants for the two-way LRU cache block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package tlc_pkg;

	localparam int NUM_SETS_DEF   = 8;
	localparam int MEM_WORDS_DEF  = 128;
	localparam int NUM_REGS_DEF   = 8;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int WORD_ADDR_W  = 7;
	localparam int ADDR_WORDS   = 1 << WORD_ADDR_W;
	localparam int REG_IDX_W    = 3;
	localparam int REG_IDX_CNT  = 1 << REG_IDX_W;
	localparam int LOAD_VALUE_W = 32;
	localparam int MEM_INIT_OFS = 5;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_STORE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

endpackage

FILE: design/two_way_lru_cache_lw_sw_top.sv
// Two-way set-associative cache, one-word blocks, LRU, with register file and backing memory.
// Depends on tlc_pkg and tlc_ram (set RAM and backing memory).
`timescale 1ns / 1ps

// Usage:
//   Input channel: in_valid/in_stall carry req_type, reg_index, word_addr.
//   Output channel: out_valid/out_stall carry hit, load_value, wrote_back,
//   one result word per request.
//   A request is accepted only in the idle state. The accept edge issues the
//   set RAM and backing memory reads; in the execute state, once the output
//   register is free or its result is taken, the block checks both ways,
//   writes set RAM, backing memory and register file, and loads the output
//   register, which raises out_valid. Until then in_stall stays high.
//   A load miss with a valid victim writes the victim back and refills
//   in the same cycle since the two addresses always differ.
//   After reset a clearing pass over max(MEM_WORDS, NUM_SETS) addresses (128 by
//   default) fills backing memory with address plus five and clears the sets;
//   in_stall is high during the pass.
//   A new request may be accepted while a result waits in the output register;
//   if the output is still stalled when that request finishes, it holds in the
//   execute state and in_stall stays high until the result drains.
module two_way_lru_cache_lw_sw_top #(
	parameter int NUM_SETS   = tlc_pkg::NUM_SETS_DEF,
	parameter int MEM_WORDS  = tlc_pkg::MEM_WORDS_DEF,
	parameter int NUM_REGS   = tlc_pkg::NUM_REGS_DEF,
	parameter int DATA_WIDTH = tlc_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [tlc_pkg::REG_IDX_W-1:0]     reg_index,
	input  logic [tlc_pkg::WORD_ADDR_W-1:0]   word_addr,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [tlc_pkg::LOAD_VALUE_W-1:0]  load_value,
	output logic                              wrote_back
);

	import tlc_pkg::*;

	localparam int SETW     = $clog2(NUM_SETS);
	localparam int MAW      = $clog2(MEM_WORDS);
	localparam int RW       = $clog2(NUM_REGS);
	localparam int ADDR_SPAN = (MEM_WORDS < ADDR_WORDS) ? MEM_WORDS : ADDR_WORDS;
	localparam int TAG_MAX  = (ADDR_SPAN - 1) / NUM_SETS;
	localparam int TAGW     = (TAG_MAX < 1) ? 1 : $clog2(TAG_MAX + 1);
	localparam int CLR_LEN  = (MEM_WORDS > NUM_SETS) ? MEM_WORDS : NUM_SETS;
	localparam int CW       = $clog2(CLR_LEN);

	typedef struct packed {
		logic                       lru;
		logic [1:0]                 v;
		logic [1:0][TAGW-1:0]       tag;
		logic [1:0][DATA_WIDTH-1:0] data;
	} set_row_t;

	// address and register decode tables
	logic [SETW-1:0] set_lut  [ADDR_WORDS];
	logic [TAGW-1:0] tag_lut  [ADDR_WORDS];
	logic [MAW-1:0]  maddr_lut[ADDR_WORDS];
	logic [RW-1:0]   reg_lut  [REG_IDX_CNT];

	for (genvar g = 0; g < ADDR_WORDS; g++) begin : g_addr_lut
		localparam int A = g % MEM_WORDS;
		assign set_lut[g]   = SETW'(A % NUM_SETS);
		assign tag_lut[g]   = TAGW'(A / NUM_SETS);
		assign maddr_lut[g] = MAW'(A);
	end

	for (genvar g = 0; g < REG_IDX_CNT; g++) begin : g_reg_lut
		assign reg_lut[g] = RW'(g % NUM_REGS);
	end

	state_t              state_q;
	logic [CW-1:0]       clr_q;
	logic                store_s1;
	logic [RW-1:0]       ridx_s1;
	logic [SETW-1:0]     set_s1;
	logic [TAGW-1:0]     tag_s1;
	logic [MAW-1:0]      maddr_s1;
	logic [DATA_WIDTH-1:0] rf_q [NUM_REGS];

	logic                  out_valid_q;
	logic                  hit_q;
	logic                  wb_q;
	logic [DATA_WIDTH-1:0] lv_q;

	logic                  accept;
	logic                  done;
	logic                  clr_last;

	set_row_t              row_rd;
	set_row_t              row_wr;
	logic [$bits(set_row_t)-1:0] row_rdata;
	logic                  set_we;
	logic [SETW-1:0]       set_waddr;
	set_row_t              set_wdata;

	logic [DATA_WIDTH-1:0] mem_rdata;
	logic                  mem_we;
	logic [MAW-1:0]        mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;

	logic                  hit0;
	logic                  hit1;
	logic                  hit_c;
	logic                  hway;
	logic                  way;
	logic                  victim_ok;
	logic                  wb_c;
	logic [MAW-1:0]        vaddr;
	logic [DATA_WIDTH-1:0] reg_rd;
	logic [DATA_WIDTH-1:0] lv_c;
	logic [DATA_WIDTH+LOAD_VALUE_W-1:0] lv_ext;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign done     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign clr_last = (clr_q == CW'(CLR_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_s1 <= (req_type == REQ_STORE);
			ridx_s1  <= reg_lut[reg_index];
			set_s1   <= set_lut[word_addr];
			tag_s1   <= tag_lut[word_addr];
			maddr_s1 <= maddr_lut[word_addr];
		end
	end

	// lookup and update
	assign row_rd = set_row_t'(row_rdata);
	assign reg_rd = rf_q[ridx_s1];
	assign hit0   = row_rd.v[0] && (row_rd.tag[0] == tag_s1);
	assign hit1   = row_rd.v[1] && (row_rd.tag[1] == tag_s1);
	assign hit_c  = hit0 || hit1;
	assign hway   = !hit0;
	assign way    = hit_c ? hway : row_rd.lru;
	assign victim_ok = !hit_c && !store_s1 && row_rd.v[way];
	assign wb_c   = victim_ok;
	assign vaddr  = MAW'(int'(row_rd.tag[way]) * NUM_SETS + int'(set_s1));
	assign lv_c   = hit_c ? row_rd.data[hway] : mem_rdata;

	always_comb begin
		row_wr = row_rd;
		if (hit_c) begin
			if (store_s1) begin
				row_wr.data[way] = reg_rd;
			end
			row_wr.lru = !way;
		end else if (!store_s1) begin
			row_wr.v[way]    = 1'b1;
			row_wr.tag[way]  = tag_s1;
			row_wr.data[way] = mem_rdata;
			row_wr.lru       = !way;
		end
	end

	always_comb begin
		set_we    = 1'b0;
		set_waddr = set_s1;
		set_wdata = row_wr;
		mem_we    = 1'b0;
		mem_waddr = maddr_s1;
		mem_wdata = reg_rd;
		if (state_q == ST_CLEAR) begin
			set_we    = (int'(clr_q) < NUM_SETS);
			set_waddr = clr_q[SETW-1:0];
			set_wdata = '0;
			mem_we    = (int'(clr_q) < MEM_WORDS);
			mem_waddr = clr_q[MAW-1:0];
			mem_wdata = DATA_WIDTH'(int'(clr_q) + MEM_INIT_OFS);
		end else if (done) begin
			set_we = hit_c || !store_s1;
			if (victim_ok) begin
				mem_we    = 1'b1;
				mem_waddr = vaddr;
				mem_wdata = row_rd.data[way];
			end else if (!hit_c && store_s1) begin
				mem_we = 1'b1;
			end
		end
	end

	tlc_ram #(
		.WIDTH($bits(set_row_t)),
		.DEPTH(NUM_SETS)
	) u_set_ram (
		.clk  (clk),
		.we   (set_we),
		.waddr(set_waddr),
		.wdata(set_wdata),
		.re   (accept),
		.raddr(set_lut[word_addr]),
		.rdata(row_rdata)
	);

	tlc_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(MEM_WORDS)
	) u_mem_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(maddr_lut[word_addr]),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else if (done && !store_s1) begin
			rf_q[ridx_s1] <= lv_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hit_q <= hit_c;
			wb_q  <= wb_c;
			lv_q  <= store_s1 ? '0 : lv_c;
		end
	end

	assign lv_ext     = {{LOAD_VALUE_W{1'b0}}, lv_q};
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign wrote_back = wb_q;
	assign load_value = lv_ext[LOAD_VALUE_W-1:0];

endmodule

FILE: design/tlc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data. No dependencies.
`timescale 1ns / 1ps

module tlc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
